// ===== rtl/core/wme_pkg.sv =====
package wme_pkg;

  localparam int unsigned SampleWidth = 16;
  localparam int unsigned MomentWidth = 64;
  localparam int unsigned CountWidth = 32;
  localparam int unsigned OrderWidth = 3;
  localparam int unsigned AccWidth = 98;
  localparam int unsigned LenWidth = 7;
  localparam int unsigned CfgIdxWidth = 2;

  localparam logic [CfgIdxWidth-1:0] CfgMomentsInUse = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CfgWindowLength = 2'd1;

  localparam logic [MomentWidth-1:0] MomentMax = {1'b0, {(MomentWidth-1){1'b1}}};
  localparam logic [MomentWidth-1:0] MomentMin = {1'b1, {(MomentWidth-1){1'b0}}};

  typedef logic signed [AccWidth-1:0] acc_t;

endpackage

// ===== rtl/core/wme_window.sv =====
module wme_window import wme_pkg::*; #(
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrWidth = 6
) (
  input  logic                   clk_i,
  input  logic                   we_i,
  input  logic [AddrWidth-1:0]   waddr_i,
  input  logic [SampleWidth-1:0] wdata_i,
  input  logic [AddrWidth-1:0]   raddr_i,
  output logic [SampleWidth-1:0] rdata_o
);

  logic [SampleWidth-1:0] mem [Depth];
  logic [SampleWidth-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/wme_divider.sv =====
module wme_divider import wme_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  acc_t                   dividend_i,
  input  logic [CountWidth-1:0]  divisor_i,
  output logic                   done_o,
  output logic [MomentWidth-1:0] quotient_o
);

  localparam int unsigned CntWidth = $clog2(AccWidth + 1);

  logic                  busy_q, busy_d, done_q, done_d, neg_q, neg_d;
  logic [CntWidth-1:0]   cnt_q, cnt_d;
  logic [AccWidth-1:0]   dvd_q, dvd_d;
  logic [CountWidth-1:0] rem_q, rem_d, div_q, div_d;
  logic [CountWidth:0]   rem_t;
  logic                  qbit;
  logic                  ovf;

  always_comb begin
    rem_t = {rem_q, dvd_q[AccWidth-1]};
    qbit = (rem_t >= {1'b0, div_q});
    busy_d = busy_q;
    done_d = 1'b0;
    neg_d = neg_q;
    cnt_d = cnt_q;
    dvd_d = dvd_q;
    rem_d = rem_q;
    div_d = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      neg_d = dividend_i[AccWidth-1];
      dvd_d = dividend_i[AccWidth-1] ? AccWidth'(-dividend_i) : dividend_i;
      rem_d = '0;
      div_d = divisor_i;
      cnt_d = '0;
    end else if (busy_q) begin
      rem_d = qbit ? CountWidth'(rem_t - {1'b0, div_q}) : rem_t[CountWidth-1:0];
      dvd_d = {dvd_q[AccWidth-2:0], qbit};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntWidth'(AccWidth - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  always_comb begin
    ovf = (dvd_q[AccWidth-1:MomentWidth] != '0);
    if (neg_q) begin
      if (ovf || dvd_q[MomentWidth-1:0] > MomentMin) quotient_o = MomentMin;
      else quotient_o = -dvd_q[MomentWidth-1:0];
    end else begin
      if (ovf || dvd_q[MomentWidth-1:0] > MomentMax) quotient_o = MomentMax;
      else quotient_o = dvd_q[MomentWidth-1:0];
    end
  end

  assign done_o = done_q;

endmodule

// ===== rtl/core/windowed_moment_estimator.sv =====
// channel  direction  handshake                 payload
// in       input      in_valid_i / in_stall_o   mode_i, sample_i
// out      output     out_valid_o / out_stall_i moment_order_o, moment_value_o,
//                                               sample_count_o, last_o
// cfg      input      cfg_we_i                  cfg_index_i, cfg_data_i
// a window update is paced by the single window memory read port and the
// one-bit-per-cycle divider, and ends with K output transactions
// reset clears count, fill and moments and restores the config defaults; the window memory is not cleared
// out_stall_i holds the output register; input is taken while the last result waits
module windowed_moment_estimator import wme_pkg::*; #(
  parameter int unsigned WINDOW_DEPTH = 64,
  parameter int unsigned MAX_MOMENTS = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          mode_i,
  input  logic signed [SampleWidth-1:0] sample_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [OrderWidth-1:0]         moment_order_o,
  output logic signed [MomentWidth-1:0] moment_value_o,
  output logic [CountWidth-1:0]         sample_count_o,
  output logic                          last_o,
  input  logic                          cfg_we_i,
  input  logic [CfgIdxWidth-1:0]        cfg_index_i,
  input  logic [LenWidth-1:0]           cfg_data_i
);

  localparam int unsigned FW = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned EW = (MAX_MOMENTS > 1) ? $clog2(MAX_MOMENTS) : 1;

  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StMulLo = 4'd1;
  localparam logic [3:0] StMulHi = 4'd2;
  localparam logic [3:0] StMulAdd = 4'd3;
  localparam logic [3:0] StRead = 4'd4;
  localparam logic [3:0] StFirst = 4'd5;
  localparam logic [3:0] StPow = 4'd6;
  localparam logic [3:0] StAcc = 4'd7;
  localparam logic [3:0] StDivStart = 4'd8;
  localparam logic [3:0] StDivWait = 4'd9;
  localparam logic [3:0] StEmit = 4'd10;

  logic [3:0]              state_q, state_d;
  logic [FW-1:0]           fill_q, fill_d, w_q, w_d, idx_q, idx_d;
  logic [CountWidth-1:0]   count_q, count_d, n_q, n_d, m_q, m_d;
  logic [OrderWidth-1:0]   kcfg_q, kcfg_d, kk_q, kk_d, e_q, e_d;
  logic [LenWidth-1:0]     len_q, len_d;
  logic [MomentWidth-1:0]  mom_q [MAX_MOMENTS];
  logic [MomentWidth-1:0]  mom_d [MAX_MOMENTS];
  acc_t                    acc_q [MAX_MOMENTS];
  acc_t                    acc_d [MAX_MOMENTS];
  logic signed [SampleWidth-1:0] x_q, x_d;
  logic signed [MomentWidth-1:0] p_q, p_d;
  logic [MomentWidth-1:0]  lo_q, lo_d;
  logic signed [MomentWidth:0] hi_q, hi_d;
  logic                    ov_q, ov_d;
  logic [OrderWidth-1:0]   oord_q, oord_d;
  logic [MomentWidth-1:0]  oval_q, oval_d;
  logic [CountWidth-1:0]   ocnt_q, ocnt_d;
  logic                    olast_q, olast_d;

  logic                    in_fire, out_fire;
  logic [OrderWidth-1:0]   keff;
  logic [31:0]             len_eff;
  logic [FW-1:0]           fill_inc;
  logic [CountWidth-1:0]   count_inc;
  logic [SampleWidth-1:0]  rdata;
  logic                    div_start, div_done;
  logic [MomentWidth-1:0]  div_q;
  logic [EW-1:0]           ei;

  assign ei = e_q[EW-1:0];
  assign in_stall_o = (state_q != StIdle);
  assign in_fire = in_valid_i && !in_stall_o;
  assign out_fire = ov_q && !out_stall_i;

  always_comb begin
    if (kcfg_q == '0) keff = OrderWidth'(1);
    else if (32'(kcfg_q) > MAX_MOMENTS) keff = OrderWidth'(MAX_MOMENTS);
    else keff = kcfg_q;
    if (len_q == '0) len_eff = 32'd1;
    else if (32'(len_q) > WINDOW_DEPTH) len_eff = WINDOW_DEPTH;
    else len_eff = 32'(len_q);
    fill_inc = fill_q + 1'b1;
    count_inc = (count_q == '1) ? count_q : count_q + 1'b1;
  end

  wme_window #(.Depth(WINDOW_DEPTH), .AddrWidth(AW)) u_window (
    .clk_i  (clk_i),
    .we_i   (in_fire && !mode_i),
    .waddr_i(fill_q[AW-1:0]),
    .wdata_i(sample_i),
    .raddr_i(idx_q[AW-1:0]),
    .rdata_o(rdata)
  );

  assign div_start = (state_q == StDivStart);

  wme_divider u_divider (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(acc_q[ei]),
    .divisor_i (n_q),
    .done_o    (div_done),
    .quotient_o(div_q)
  );

  always_comb begin
    state_d = state_q;
    fill_d = fill_q;
    count_d = count_q;
    kcfg_d = kcfg_q;
    len_d = len_q;
    kk_d = kk_q;
    w_d = w_q;
    n_d = n_q;
    m_d = m_q;
    idx_d = idx_q;
    e_d = e_q;
    mom_d = mom_q;
    acc_d = acc_q;
    x_d = x_q;
    p_d = p_q;
    lo_d = lo_q;
    hi_d = hi_q;
    ov_d = out_fire ? 1'b0 : ov_q;
    oord_d = oord_q;
    oval_d = oval_q;
    ocnt_d = ocnt_q;
    olast_d = olast_q;

    if (cfg_we_i) begin
      if (cfg_index_i == CfgMomentsInUse) kcfg_d = cfg_data_i[OrderWidth-1:0];
      else if (cfg_index_i == CfgWindowLength) len_d = cfg_data_i;
    end

    case (state_q)
      StIdle: begin
        if (in_fire) begin
          if (mode_i || (32'(fill_inc) >= len_eff)) begin
            w_d = mode_i ? fill_q : fill_inc;
            n_d = mode_i ? count_q : count_inc;
            m_d = (33'(n_d) >= 33'(w_d)) ? CountWidth'(n_d - CountWidth'(w_d)) : '0;
            kk_d = keff;
            e_d = '0;
            fill_d = '0;
            state_d = (n_d == '0) ? StEmit : StMulLo;
          end else begin
            fill_d = fill_inc;
          end
          if (!mode_i) count_d = count_inc;
        end
      end
      StMulLo: begin
        lo_d = 64'(mom_q[ei][31:0]) * 64'(m_q);
        state_d = StMulHi;
      end
      StMulHi: begin
        hi_d = $signed(mom_q[ei][63:32]) * $signed({1'b0, m_q});
        state_d = StMulAdd;
      end
      StMulAdd: begin
        acc_d[ei] = (AccWidth'(hi_q) <<< 32) + acc_t'({1'b0, lo_q});
        e_d = e_q + 1'b1;
        idx_d = '0;
        if (e_q + 1'b1 == kk_q) begin
          e_d = '0;
          state_d = (w_q == '0) ? StDivStart : StRead;
        end else begin
          state_d = StMulLo;
        end
      end
      StRead: begin
        state_d = StFirst;
      end
      StFirst: begin
        x_d = $signed(rdata);
        p_d = MomentWidth'($signed(rdata));
        acc_d[0] = acc_q[0] + (AccWidth'($signed(rdata)) <<< 24);
        e_d = OrderWidth'(1);
        if (kk_q == OrderWidth'(1)) begin
          idx_d = idx_q + 1'b1;
          state_d = (idx_q + 1'b1 == w_q) ? StDivStart : StRead;
          e_d = '0;
        end else begin
          state_d = StPow;
        end
      end
      StPow: begin
        p_d = MomentWidth'(p_q * x_q);
        state_d = StAcc;
      end
      StAcc: begin
        acc_d[ei] = acc_q[ei] + (AccWidth'(p_q) <<< (24 - 8 * int'(e_q)));
        e_d = e_q + 1'b1;
        if (e_q + 1'b1 == kk_q) begin
          e_d = '0;
          idx_d = idx_q + 1'b1;
          state_d = (idx_q + 1'b1 == w_q) ? StDivStart : StRead;
        end else begin
          state_d = StPow;
        end
      end
      StDivStart: begin
        state_d = StDivWait;
      end
      StDivWait: begin
        if (div_done) begin
          mom_d[ei] = div_q;
          e_d = e_q + 1'b1;
          if (e_q + 1'b1 == kk_q) begin
            e_d = '0;
            state_d = StEmit;
          end else begin
            state_d = StDivStart;
          end
        end
      end
      StEmit: begin
        if (!ov_q || out_fire) begin
          ov_d = 1'b1;
          oord_d = e_q + 1'b1;
          oval_d = mom_q[ei];
          ocnt_d = n_q;
          olast_d = (e_q + 1'b1 == kk_q);
          e_d = e_q + 1'b1;
          if (e_q + 1'b1 == kk_q) begin
            e_d = '0;
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      fill_q <= '0;
      count_q <= '0;
      kcfg_q <= OrderWidth'(2);
      len_q <= LenWidth'(64);
      kk_q <= OrderWidth'(1);
      e_q <= '0;
      ov_q <= 1'b0;
      for (int i = 0; i < MAX_MOMENTS; i++) begin
        mom_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      fill_q <= fill_d;
      count_q <= count_d;
      kcfg_q <= kcfg_d;
      len_q <= len_d;
      kk_q <= kk_d;
      e_q <= e_d;
      ov_q <= ov_d;
      mom_q <= mom_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q <= w_d;
    n_q <= n_d;
    m_q <= m_d;
    idx_q <= idx_d;
    acc_q <= acc_d;
    x_q <= x_d;
    p_q <= p_d;
    lo_q <= lo_d;
    hi_q <= hi_d;
    oord_q <= oord_d;
    oval_q <= oval_d;
    ocnt_q <= ocnt_d;
    olast_q <= olast_d;
  end

  assign out_valid_o = ov_q;
  assign moment_order_o = oord_q;
  assign moment_value_o = oval_q;
  assign sample_count_o = ocnt_q;
  assign last_o = olast_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fill_q) < WINDOW_DEPTH) else $error("window fill out of range");

  a_last_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> moment_order_o == kk_q) else $error("last on wrong order");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == StDivWait) else $error("divider done outside wait");

endmodule

// ===== dv/tb_windowed_moment_estimator.sv =====
module tb_windowed_moment_estimator;
  import wme_pkg::*;

  typedef struct {
    logic                   mode;
    logic [SampleWidth-1:0] sample;
  } sample_txn_t;

  typedef struct {
    logic [OrderWidth-1:0]         order;
    logic signed [MomentWidth-1:0] value;
    logic [CountWidth-1:0]         count;
    logic                          last;
  } moment_txn_t;

  localparam int unsigned Depth = 64;
  localparam int unsigned Orders = 4;
  localparam logic ModeRecord = 1'b0;
  localparam logic ModeFlush = 1'b1;
  localparam logic [CfgIdxWidth-1:0] CfgSpare2 = 2'd2;
  localparam logic [CfgIdxWidth-1:0] CfgSpare3 = 2'd3;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic                          mode_d = 1'b0;
  logic signed [SampleWidth-1:0] sample_d = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [OrderWidth-1:0]         moment_order;
  logic signed [MomentWidth-1:0] moment_value;
  logic [CountWidth-1:0]         sample_count;
  logic                          last;
  logic                          cfg_we = 1'b0;
  logic [CfgIdxWidth-1:0]        cfg_index = '0;
  logic [LenWidth-1:0]           cfg_data = '0;

  sample_txn_t pending_samples[$];
  moment_txn_t expected_moments[$];

  // shadow of the block state
  logic signed [SampleWidth-1:0] win_mem[Depth];
  int unsigned                   win_fill;
  logic [CountWidth-1:0]         total_cnt;
  logic signed [MomentWidth-1:0] moments[Orders];
  logic [2:0]                    k_reg;
  logic [LenWidth-1:0]           len_reg;

  int  errors = 0;
  bit  quiet = 1'b0;
  int  in_gap = 0;
  int  out_gap = 0;
  logic long_hold_req = 1'b0;
  bit  hold_done = 1'b0;
  int  hold_cnt = 0;

  windowed_moment_estimator i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .mode_i         (mode_d),
    .sample_i       (sample_d),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .moment_order_o (moment_order),
    .moment_value_o (moment_value),
    .sample_count_o (sample_count),
    .last_o         (last),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  task automatic update_moments();
    int unsigned kc, w, k, i;
    logic signed [127:0] acc, wt, x, p, q, nn;
    moment_txn_t t;
    kc = (k_reg < 1) ? 1 : (k_reg > Orders) ? Orders : k_reg;
    w = (win_fill > Depth) ? Depth : win_fill;
    for (k = 1; k <= kc; k++) begin
      if (total_cnt != 0) begin
        acc = 128'(moments[k-1]);
        wt = (total_cnt >= w) ? 128'(total_cnt - w) : '0;
        acc = acc * wt;
        for (i = 0; i < w; i++) begin
          x = 128'(win_mem[i]);
          p = x;
          repeat (k - 1) p = p * x;
          acc = acc + (p <<< (32 - 8 * k));
        end
        nn = 128'(total_cnt);
        q = acc / nn;
        if (q > $signed({64'd0, MomentMax})) q = $signed({64'd0, MomentMax});
        else if (q < $signed({{64{1'b1}}, MomentMin})) q = $signed({{64{1'b1}}, MomentMin});
        moments[k-1] = q[63:0];
      end
      t.order = k[OrderWidth-1:0];
      t.value = moments[k-1];
      t.count = total_cnt;
      t.last = (k == kc);
      expected_moments.push_back(t);
    end
    win_fill = 0;
  endtask

  task automatic predict_txn(logic mode, logic signed [SampleWidth-1:0] smp);
    int unsigned len;
    if (mode == ModeFlush) begin
      update_moments();
    end else begin
      len = (len_reg < 1) ? 1 : (len_reg > Depth) ? Depth : len_reg;
      if (win_fill >= Depth) win_fill = Depth - 1;
      win_mem[win_fill] = smp;
      win_fill++;
      if (total_cnt != 32'hFFFF_FFFF) total_cnt++;
      if (win_fill >= len) update_moments();
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (quiet || r < 13) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // driver
  always @(posedge clk_i) begin
    sample_txn_t nxt;
    if (in_valid && !in_stall) predict_txn(mode_d, sample_d);
    if (!in_valid || !in_stall) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (pending_samples.size() > 0) begin
        nxt = pending_samples.pop_front();
        in_valid <= 1'b1;
        mode_d <= nxt.mode;
        sample_d <= nxt.sample;
        in_gap = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk_i) begin
    if (long_hold_req && !hold_done) begin
      hold_cnt <= 3000;
      hold_done <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    moment_txn_t e;
    bit stall_next;
    if (out_valid && !out_stall) begin
      if (expected_moments.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected transaction order %0d value %0h",
                                   moment_order, moment_value);
      end else begin
        e = expected_moments.pop_front();
        if (moment_order !== e.order || moment_value !== e.value ||
            sample_count !== e.count || last !== e.last) begin
          errors++;
          if (errors <= 10)
            $display("mismatch exp k=%0d v=%0h n=%0d l=%0b act k=%0d v=%0h n=%0d l=%0b",
                     e.order, e.value, e.count, e.last,
                     moment_order, moment_value, sample_count, last);
        end
      end
    end
    if (out_gap > 0) begin
      out_gap--;
      stall_next = 1'b1;
    end else begin
      stall_next = 1'b0;
      if (!quiet && $urandom_range(0, 9) < 3) begin
        stall_next = 1'b1;
        out_gap = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(20, 60);
      end
    end
    out_stall <= stall_next || (hold_cnt > 0);
  end

  task automatic write_cfg(logic [CfgIdxWidth-1:0] idx, logic [LenWidth-1:0] val);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == CfgMomentsInUse) k_reg = val[2:0];
    else if (idx == CfgWindowLength) len_reg = val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic push_txn(logic mode, logic [SampleWidth-1:0] smp);
    sample_txn_t t;
    t.mode = mode;
    t.sample = smp;
    pending_samples.push_back(t);
  endtask

  task automatic drain();
    do @(posedge clk_i);
    while (pending_samples.size() != 0 || in_valid || expected_moments.size() != 0);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic logic [SampleWidth-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return SampleWidth'($urandom_range(0, 15) - 8);
      default: return SampleWidth'($urandom_range(0, 65535));
    endcase
  endfunction

  initial begin
    int ph, j, ks, ls;
    win_fill = 0;
    total_cnt = '0;
    for (j = 0; j < Orders; j++) moments[j] = '0;
    k_reg = 3'd2;
    len_reg = 7'd64;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // flush before any sample, extremes, then a flush of an empty window
    push_txn(ModeFlush, 16'h1234);
    push_txn(ModeRecord, 16'h7FFF);
    push_txn(ModeRecord, 16'h8000);
    push_txn(ModeRecord, 16'h0000);
    push_txn(ModeRecord, 16'hFFFF);
    push_txn(ModeRecord, 16'h0001);
    push_txn(ModeFlush, 16'hFFFF);
    push_txn(ModeFlush, 16'h0000);
    drain();
    write_cfg(CfgMomentsInUse, 7'd0);
    write_cfg(CfgWindowLength, 7'd0);
    push_txn(ModeRecord, 16'h8000);
    push_txn(ModeRecord, 16'h7FFF);
    drain();
    write_cfg(CfgMomentsInUse, 7'd7);
    write_cfg(CfgWindowLength, 7'd127);
    write_cfg(CfgSpare2, 7'd5);
    write_cfg(CfgSpare3, 7'd0);
    for (j = 0; j < 5; j++) push_txn(ModeRecord, 16'h8000);
    drain();
    // length lowered below the current fill
    write_cfg(CfgWindowLength, 7'd3);
    push_txn(ModeRecord, 16'h7FFF);
    drain();

    for (ph = 0; ph < 8; ph++) begin
      quiet = (ph == 2);
      ks = (ph < 4) ? ph + 1 : $urandom_range(0, 7);
      ls = (ph == 6) ? 64 : $urandom_range(1, 8);
      write_cfg(CfgMomentsInUse, LenWidth'(ks));
      write_cfg(CfgWindowLength, LenWidth'(ls));
      for (j = 0; j < 22; j++)
        push_txn(($urandom_range(0, 9) == 0) ? ModeFlush : ModeRecord, rand_sample());
      drain();
    end

    // receiver holds off while the sender keeps going
    quiet = 1'b1;
    write_cfg(CfgMomentsInUse, 7'd4);
    write_cfg(CfgWindowLength, 7'd4);
    long_hold_req <= 1'b1;
    for (j = 0; j < 30; j++) push_txn(ModeRecord, rand_sample());
    drain();
    quiet = 1'b0;

    if (errors == 0 && expected_moments.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #12000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/wme_pkg.sv
rtl/core/wme_window.sv
rtl/core/wme_divider.sv
rtl/core/windowed_moment_estimator.sv
dv/tb_windowed_moment_estimator.sv
